// File: design/pabs_pkg.sv
// pabs_pkg: shared codes, widths and reset values for the alarm beep sequencer
// no dependencies; imported by priority_alarm_beep_sequencer_unit
`default_nettype none

package pabs_pkg;

    // field widths fixed by the interface
    localparam int unsigned MS_W     = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [1:0]           opcode_t;
    typedef logic [1:0]           kind_t;
    typedef logic [1:0]           therm_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // input operations
    localparam opcode_t OP_TICK = 2'd0;
    localparam opcode_t OP_PLAY = 2'd1;
    localparam opcode_t OP_STOP = 2'd2;

    // thermal state codes
    localparam therm_t THERM_LIMIT = 2'd1;
    localparam therm_t THERM_FAULT = 2'd2;

    // reported alarm kinds
    localparam kind_t KIND_NONE     = 2'd0;
    localparam kind_t KIND_LOW_BATT = 2'd1;
    localparam kind_t KIND_LIMIT    = 2'd2;
    localparam kind_t KIND_FAULT    = 2'd3;

    // configuration register indexes
    localparam cfg_idx_t REG_BEEP_ON        = 3'd0;
    localparam cfg_idx_t REG_BEEP_OFF       = 3'd1;
    localparam cfg_idx_t REG_HOT_PERIOD     = 3'd2;
    localparam cfg_idx_t REG_LOW_BATT_PERIOD = 3'd3;
    localparam cfg_idx_t REG_FAULT_BEEPS    = 3'd4;
    localparam cfg_idx_t REG_LIMIT_BEEPS    = 3'd5;
    localparam cfg_idx_t REG_LOW_BATT_BEEPS = 3'd6;

    // configuration reset values
    localparam logic [MS_W-1:0]    RST_BEEP_ON         = 16'd200;
    localparam logic [MS_W-1:0]    RST_BEEP_OFF        = 16'd200;
    localparam logic [MS_W-1:0]    RST_HOT_PERIOD      = 16'd4000;
    localparam logic [MS_W-1:0]    RST_LOW_BATT_PERIOD = 16'd8000;
    localparam logic [COUNT_W-1:0] RST_FAULT_BEEPS     = 8'd3;
    localparam logic [COUNT_W-1:0] RST_LIMIT_BEEPS     = 8'd2;
    localparam logic [COUNT_W-1:0] RST_LOW_BATT_BEEPS  = 8'd6;

endpackage

`default_nettype wire

// File: design/priority_alarm_beep_sequencer_unit.sv
// priority_alarm_beep_sequencer_unit: alarm selection, burst timing and on/off beep sequencing
// depends on pabs_pkg
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid in_ready opcode delta_ms thermal_state      | to block
//          | thermal_hot low_batt_warn beep_count                 |
//  out     | out_valid out_ready tone_enable beeps_remaining      | from block
//          | alarm_kind                                           |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data               | to block
//
// one beat per cycle while the output is not stalled: a beat is held in the
// input register, then the step logic updates the sequencer state and
// loads the result register; reset clears the pipeline valids and sequencer
// state and loads the default configuration; a stalled output holds both
// stages, bubbles are squeezed out
`default_nettype none

module priority_alarm_beep_sequencer_unit
    import pabs_pkg::*;
#(
    parameter int unsigned TIME_BITS = 17
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input beats
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [MS_W-1:0]      delta_ms,
    input  wire logic [1:0]           thermal_state,
    input  wire logic                 thermal_hot,
    input  wire logic                 low_batt_warn,
    input  wire logic [COUNT_W-1:0]   beep_count,
    // result beats
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      tone_enable,
    output logic [COUNT_W-1:0]        beeps_remaining,
    output logic [1:0]                alarm_kind,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MS_W-1:0]      cfg_data
);

    localparam int unsigned PAD_W = TIME_BITS - MS_W;

    // configuration registers
    logic [MS_W-1:0]    beep_on_reg;
    logic [MS_W-1:0]    beep_off_reg;
    logic [MS_W-1:0]    hot_period_reg;
    logic [MS_W-1:0]    low_batt_period_reg;
    logic [COUNT_W-1:0] fault_beeps_reg;
    logic [COUNT_W-1:0] limit_beeps_reg;
    logic [COUNT_W-1:0] low_batt_beeps_reg;

    // input stage
    logic               in_valid_reg;
    opcode_t            opcode_reg;
    logic [MS_W-1:0]    elapsed_reg;
    therm_t             therm_reg;
    logic               hot_reg;
    logic               low_batt_reg;
    logic [COUNT_W-1:0] count_reg;

    // sequencer state
    logic [COUNT_W-1:0]   beeps_left_reg, beeps_left_next;
    logic                 tone_on_reg, tone_on_next;
    logic [TIME_BITS-1:0] phase_time_reg, phase_time_next;
    logic [TIME_BITS-1:0] alarm_time_reg, alarm_time_next;
    logic [COUNT_W-1:0]   last_beeps_reg, last_beeps_next;

    // result stage
    logic               out_valid_reg;
    logic               tone_out_reg;
    logic [COUNT_W-1:0] beeps_out_reg;
    kind_t              kind_out_reg;
    kind_t              kind_next;

    logic advance;

    // handshake: result register frees up when empty or taken
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign tone_enable     = tone_out_reg;
    assign beeps_remaining = beeps_out_reg;
    assign alarm_kind      = kind_out_reg;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beep_on_reg         <= RST_BEEP_ON;
            beep_off_reg        <= RST_BEEP_OFF;
            hot_period_reg      <= RST_HOT_PERIOD;
            low_batt_period_reg <= RST_LOW_BATT_PERIOD;
            fault_beeps_reg     <= RST_FAULT_BEEPS;
            limit_beeps_reg     <= RST_LIMIT_BEEPS;
            low_batt_beeps_reg  <= RST_LOW_BATT_BEEPS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BEEP_ON:         beep_on_reg         <= cfg_data;
                REG_BEEP_OFF:        beep_off_reg        <= cfg_data;
                REG_HOT_PERIOD:      hot_period_reg      <= cfg_data;
                REG_LOW_BATT_PERIOD: low_batt_period_reg <= cfg_data;
                REG_FAULT_BEEPS:     fault_beeps_reg     <= cfg_data[COUNT_W-1:0];
                REG_LIMIT_BEEPS:     limit_beeps_reg     <= cfg_data[COUNT_W-1:0];
                REG_LOW_BATT_BEEPS:  low_batt_beeps_reg  <= cfg_data[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            opcode_reg   <= opcode;
            elapsed_reg  <= delta_ms;
            therm_reg    <= thermal_state;
            hot_reg      <= thermal_hot;
            low_batt_reg <= low_batt_warn;
            count_reg    <= beep_count;
        end
    end

    // step logic intermediates
    logic [COUNT_W-1:0]   sel_beeps;
    logic [MS_W-1:0]      sel_period;
    logic [COUNT_W-1:0]   burst_beeps;
    logic                 burst_tone;
    logic [TIME_BITS-1:0] burst_phase;
    logic [TIME_BITS-1:0] alarm_sum;
    logic [TIME_BITS-1:0] alarm_base;
    logic [TIME_BITS-1:0] phase_sum;
    logic [TIME_BITS-1:0] elapsed_ext;

    assign elapsed_ext = {{PAD_W{1'b0}}, elapsed_reg};

    // alarm priority select
    always_comb
    begin
        kind_next  = KIND_NONE;
        sel_beeps  = '0;
        sel_period = '0;
        if (therm_reg == THERM_FAULT && hot_reg)
        begin
            kind_next  = KIND_FAULT;
            sel_beeps  = fault_beeps_reg;
            sel_period = hot_period_reg;
        end
        else if (therm_reg == THERM_LIMIT && hot_reg)
        begin
            kind_next  = KIND_LIMIT;
            sel_beeps  = limit_beeps_reg;
            sel_period = hot_period_reg;
        end
        else if (low_batt_reg)
        begin
            kind_next  = KIND_LOW_BATT;
            sel_beeps  = low_batt_beeps_reg;
            sel_period = low_batt_period_reg;
        end
    end

    // next state for one beat
    always_comb
    begin
        beeps_left_next = beeps_left_reg;
        tone_on_next    = tone_on_reg;
        phase_time_next = phase_time_reg;
        alarm_time_next = alarm_time_reg;
        last_beeps_next = last_beeps_reg;
        burst_beeps     = beeps_left_reg;
        burst_tone      = tone_on_reg;
        burst_phase     = phase_time_reg;
        alarm_base      = alarm_time_reg;
        alarm_sum       = '0;
        phase_sum       = '0;

        case (opcode_reg)
            OP_PLAY:
            begin
                beeps_left_next = count_reg;
                tone_on_next    = (count_reg != '0);
                phase_time_next = '0;
            end
            OP_STOP:
            begin
                beeps_left_next = '0;
                tone_on_next    = 1'b0;
                phase_time_next = '0;
            end
            OP_TICK:
            begin
                // alarm burst restart and period timer
                if (sel_beeps != '0)
                begin
                    if (alarm_time_reg == '0 || sel_beeps != last_beeps_reg)
                    begin
                        burst_beeps = sel_beeps;
                        burst_tone  = 1'b1;
                        burst_phase = '0;
                        alarm_base  = '0;
                    end
                    last_beeps_next = sel_beeps;
                    alarm_sum       = alarm_base + elapsed_ext;
                    if (alarm_sum >= {{PAD_W{1'b0}}, sel_period})
                    begin
                        alarm_time_next = '0;
                    end
                    else
                    begin
                        alarm_time_next = alarm_sum;
                    end
                end
                else
                begin
                    alarm_time_next = '0;
                    last_beeps_next = '0;
                end

                // on/off beep sequencer
                beeps_left_next = burst_beeps;
                tone_on_next    = burst_tone;
                phase_time_next = burst_phase;
                if (burst_beeps != '0 || burst_tone)
                begin
                    phase_sum       = burst_phase + elapsed_ext;
                    phase_time_next = phase_sum;
                    if (burst_tone)
                    begin
                        if (phase_sum >= {{PAD_W{1'b0}}, beep_on_reg})
                        begin
                            tone_on_next    = 1'b0;
                            phase_time_next = '0;
                            if (burst_beeps != '0)
                            begin
                                beeps_left_next = burst_beeps - 1'b1;
                            end
                        end
                    end
                    else if (phase_sum >= {{PAD_W{1'b0}}, beep_off_reg})
                    begin
                        tone_on_next    = 1'b1;
                        phase_time_next = '0;
                    end
                end
            end
            default:
            begin
                // unused opcode leaves the state alone
            end
        endcase
    end

    // sequencer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beeps_left_reg <= '0;
            tone_on_reg    <= 1'b0;
            phase_time_reg <= '0;
            alarm_time_reg <= '0;
            last_beeps_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                beeps_left_reg <= beeps_left_next;
                tone_on_reg    <= tone_on_next;
                phase_time_reg <= phase_time_next;
                alarm_time_reg <= alarm_time_next;
                last_beeps_reg <= last_beeps_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tone_out_reg  <= tone_on_next;
            beeps_out_reg <= beeps_left_next;
            kind_out_reg  <= (opcode_reg == OP_TICK) ? kind_next : KIND_NONE;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_priority_alarm_beep_sequencer_unit.sv
// tb_priority_alarm_beep_sequencer_unit: self-checking bench for the alarm beep sequencer
// drives random-gapped beats and register writes, predicts or tabulates each result beat
// depends on pabs_pkg and priority_alarm_beep_sequencer_unit
`timescale 1ns / 1ps

module tb_priority_alarm_beep_sequencer_unit;
    import pabs_pkg::*;

    localparam int TB_TIME_BITS = 17;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_BEATS  = 155;
    localparam int DRAIN_LIMIT  = 100000;

    // codes the package leaves unnamed
    localparam opcode_t  OP_IGNORED   = 2'd3;
    localparam therm_t   THERM_NORMAL = 2'd0;
    localparam therm_t   THERM_OTHER  = 2'd3;
    localparam cfg_idx_t REG_UNUSED   = 3'd7;

    typedef struct packed {
        opcode_t             op;
        logic [MS_W-1:0]     elapsed;
        therm_t              ts;
        logic                hot;
        logic                lowb;
        logic [COUNT_W-1:0]  count;
    } beat_t;

    typedef struct packed {
        logic                tone;
        logic [COUNT_W-1:0]  left;
        kind_t               kind;
    } tone_t;

    typedef struct packed {
        logic                is_cfg;
        cfg_idx_t            idx;
        logic [MS_W-1:0]     data;
        beat_t               beat;
        logic                typed;
        tone_t               want;
    } dir_row_t;

    // block ports
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           opcode        = '0;
    logic [MS_W-1:0]      delta_ms      = '0;
    logic [1:0]           thermal_state = '0;
    logic                 thermal_hot   = 1'b0;
    logic                 low_batt_warn = 1'b0;
    logic [COUNT_W-1:0]   beep_count    = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic                 tone_enable;
    logic [COUNT_W-1:0]   beeps_remaining;
    logic [1:0]           alarm_kind;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [MS_W-1:0]      cfg_data      = '0;

    // predicted sequencer state and register copies
    logic [COUNT_W-1:0]      m_beeps_left;
    logic                    m_tone_on;
    logic [TB_TIME_BITS-1:0] m_phase;
    logic [TB_TIME_BITS-1:0] m_alarm_time;
    logic [COUNT_W-1:0]      m_last_beeps;
    logic [MS_W-1:0]         c_on      = RST_BEEP_ON;
    logic [MS_W-1:0]         c_off     = RST_BEEP_OFF;
    logic [MS_W-1:0]         c_hot_per = RST_HOT_PERIOD;
    logic [MS_W-1:0]         c_lb_per  = RST_LOW_BATT_PERIOD;
    logic [COUNT_W-1:0]      c_fault   = RST_FAULT_BEEPS;
    logic [COUNT_W-1:0]      c_limit   = RST_LIMIT_BEEPS;
    logic [COUNT_W-1:0]      c_lb_beeps = RST_LOW_BATT_BEEPS;

    tone_t    pending_tones [$];
    dir_row_t dir_rows [$];
    int       beats_sent    = 0;
    int       tones_checked = 0;
    int       mismatches    = 0;
    int       ready_hold    = 0;
    int       ready_roll;
    logic     rx_calm       = 1'b0;
    tone_t    got_tone;
    tone_t    want_tone;

    priority_alarm_beep_sequencer_unit #(
        .TIME_BITS(TB_TIME_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .delta_ms(delta_ms),
        .thermal_state(thermal_state),
        .thermal_hot(thermal_hot),
        .low_batt_warn(low_batt_warn),
        .beep_count(beep_count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tone_enable(tone_enable),
        .beeps_remaining(beeps_remaining),
        .alarm_kind(alarm_kind),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock and reset
    always #5 clk = ~clk;

    initial
    begin
        m_beeps_left = '0;
        m_tone_on    = 1'b0;
        m_phase      = '0;
        m_alarm_time = '0;
        m_last_beeps = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // start a burst, a zero count silences the buzzer
    function automatic void load_burst(input logic [COUNT_W-1:0] n);
        m_beeps_left = n;
        m_tone_on    = (n != 0);
        m_phase      = '0;
    endfunction

    // advance the predicted sequencer by one beat and return its result
    function automatic tone_t predict_tone(input beat_t b);
        tone_t              r;
        kind_t              kind;
        logic [COUNT_W-1:0] beeps;
        logic [MS_W-1:0]    period;
        kind   = KIND_NONE;
        beeps  = '0;
        period = '0;
        if (b.op == OP_PLAY)
        begin
            load_burst(b.count);
        end
        else if (b.op == OP_STOP)
        begin
            load_burst('0);
        end
        else if (b.op == OP_TICK)
        begin
            // priority pick, thermal state three counts as normal
            if (b.ts == THERM_FAULT && b.hot)
            begin
                kind = KIND_FAULT; beeps = c_fault; period = c_hot_per;
            end
            else if (b.ts == THERM_LIMIT && b.hot)
            begin
                kind = KIND_LIMIT; beeps = c_limit; period = c_hot_per;
            end
            else if (b.lowb)
            begin
                kind = KIND_LOW_BATT; beeps = c_lb_beeps; period = c_lb_per;
            end

            // burst restart on period wrap or count change
            if (beeps != 0)
            begin
                if (m_alarm_time == 0 || beeps != m_last_beeps)
                begin
                    load_burst(beeps);
                    m_last_beeps = beeps;
                    m_alarm_time = '0;
                end
                m_alarm_time = m_alarm_time + b.elapsed;
                if (m_alarm_time >= period)
                    m_alarm_time = '0;
            end
            else
            begin
                m_alarm_time = '0;
                m_last_beeps = '0;
            end

            // on/off phase of the current beep
            if (m_beeps_left != 0 || m_tone_on)
            begin
                m_phase = m_phase + b.elapsed;
                if (m_tone_on)
                begin
                    if (m_phase >= c_on)
                    begin
                        m_tone_on = 1'b0;
                        m_phase   = '0;
                        if (m_beeps_left > 0)
                            m_beeps_left = m_beeps_left - 1'b1;
                    end
                end
                else if (m_phase >= c_off)
                begin
                    m_tone_on = 1'b1;
                    m_phase   = '0;
                end
            end
        end
        r.tone = m_tone_on;
        r.left = m_beeps_left;
        r.kind = kind;
        return r;
    endfunction

    // directed table rows
    task automatic add_beat(input opcode_t op, input logic [MS_W-1:0] el, input therm_t ts,
                            input logic hot, input logic lb, input logic [COUNT_W-1:0] cnt,
                            input logic typed, input logic tone,
                            input logic [COUNT_W-1:0] left, input kind_t kind);
        dir_row_t row;
        row        = '0;
        row.beat   = '{op: op, elapsed: el, ts: ts, hot: hot, lowb: lb, count: cnt};
        row.typed  = typed;
        row.want   = '{tone: tone, left: left, kind: kind};
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input cfg_idx_t idx, input logic [MS_W-1:0] data);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        dir_rows.push_back(row);
    endtask

    // one register write beat, cfg_valid is left high for back-to-back writes
    task automatic write_reg(input cfg_idx_t idx, input logic [MS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_BEEP_ON:         c_on       = data;
            REG_BEEP_OFF:        c_off      = data;
            REG_HOT_PERIOD:      c_hot_per  = data;
            REG_LOW_BATT_PERIOD: c_lb_per   = data;
            REG_FAULT_BEEPS:     c_fault    = data[COUNT_W-1:0];
            REG_LIMIT_BEEPS:     c_limit    = data[COUNT_W-1:0];
            REG_LOW_BATT_BEEPS:  c_lb_beeps = data[COUNT_W-1:0];
            default:             ;
        endcase
    endtask

    // hold the input side idle until every predicted result has come back
    task automatic drain_results(input int max_cycles);
        int n;
        n = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (pending_tones.size() != 0 && n < max_cycles);
    endtask

    // one input beat after an optional gap, prediction queued on acceptance
    task automatic send_beat(input beat_t b, input int gap, input logic typed,
                             input tone_t want);
        tone_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= b.op;
        delta_ms      <= b.elapsed;
        thermal_state <= b.ts;
        thermal_hot   <= b.hot;
        low_batt_warn <= b.lowb;
        beep_count    <= b.count;
        do @(posedge clk); while (!in_ready);
        predicted = predict_tone(b);
        pending_tones.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // result side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_calm)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold = $urandom_range(0, 5);
            end
            else if (ready_roll < 92)
            begin
                out_ready  <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_tone = '{tone: tone_enable, left: beeps_remaining, kind: alarm_kind};
            if (pending_tones.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tone %0b left %0d kind %0d",
                             got_tone.tone, got_tone.left, got_tone.kind);
            end
            else
            begin
                want_tone = pending_tones.pop_front();
                if (got_tone.tone !== want_tone.tone || got_tone.left !== want_tone.left ||
                    got_tone.kind !== want_tone.kind)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                                 tones_checked, want_tone.tone, want_tone.left,
                                 want_tone.kind, got_tone.tone, got_tone.left,
                                 got_tone.kind);
                end
                tones_checked++;
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t        row;
        beat_t           b;
        int              i;
        int              p;
        int              gap;
        int              roll;
        int              scale;
        logic [MS_W-1:0] v_on;
        logic [MS_W-1:0] v_off;
        logic [MS_W-1:0] v_hot;
        logic [MS_W-1:0] v_lb;
        logic [7:0]      v_fault;
        logic [7:0]      v_limit;
        logic [7:0]      v_lbb;
        therm_t          cur_ts;
        logic            cur_hot;
        logic            cur_lb;

        // directed part, reset register values first
        add_beat(OP_TICK, 16'd0, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_IGNORED, 16'hFFFF, THERM_OTHER, 1'b1, 1'b1, 8'hFF,
                 1'b1, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_PLAY, 16'd0, THERM_NORMAL, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 8'd255, KIND_NONE);
        add_beat(OP_TICK, 16'hFFFF, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd199, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd1, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_STOP, 16'hFFFF, THERM_FAULT, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 8'd0, KIND_NONE);
        // play with zero count behaves as stop
        add_beat(OP_PLAY, 16'd0, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd0, THERM_FAULT, 1'b1, 1'b0, 8'd0, 1'b1, 1'b1, 8'd3, KIND_FAULT);
        add_beat(OP_TICK, 16'd200, THERM_FAULT, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd100, THERM_LIMIT, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd50, THERM_LIMIT, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        // thermal state three is treated as normal
        add_beat(OP_TICK, 16'd10, THERM_OTHER, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd10, THERM_OTHER, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'hFFFF, THERM_NORMAL, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd0, THERM_FAULT, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_PLAY, 16'd5, THERM_NORMAL, 1'b0, 1'b0, 8'd1, 1'b1, 1'b1, 8'd1, KIND_NONE);
        add_beat(OP_IGNORED, 16'd0, THERM_NORMAL, 1'b0, 1'b0, 8'd0,
                 1'b0, 1'b0, 8'd0, KIND_NONE);
        // selected alarm with zero beeps masks the lower ones
        add_cfg(REG_FAULT_BEEPS, 16'hAB00);
        add_beat(OP_TICK, 16'd5, THERM_FAULT, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd5, THERM_FAULT, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        // register extremes
        add_cfg(REG_BEEP_ON, 16'hFFFF);
        add_cfg(REG_BEEP_OFF, 16'd1);
        add_cfg(REG_HOT_PERIOD, 16'hFFFF);
        add_cfg(REG_LOW_BATT_PERIOD, 16'd1);
        add_cfg(REG_LIMIT_BEEPS, 16'h00FF);
        add_cfg(REG_LOW_BATT_BEEPS, 16'h5AFF);
        add_cfg(REG_UNUSED, 16'h1234);
        add_beat(OP_TICK, 16'hFFFF, THERM_LIMIT, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'hFFFF, THERM_LIMIT, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'd1, THERM_NORMAL, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_PLAY, 16'd0, THERM_NORMAL, 1'b0, 1'b0, 8'd2, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'hFFFF, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);
        add_beat(OP_TICK, 16'hFFFF, THERM_NORMAL, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0, KIND_NONE);

        wait (rst_n === 1'b1);
        @(posedge clk);

        // walk the directed table, register rows only once the block is idle
        for (i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                if (!cfg_valid)
                    drain_results(DRAIN_LIMIT);
                write_reg(row.idx, row.data);
            end
            else
            begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                send_beat(row.beat, 0, row.typed, row.want);
            end
        end

        // random phases, each with its own register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            drain_results(DRAIN_LIMIT);
            case (p)
                0:
                begin
                    v_on = 16'd1; v_off = 16'd1; v_hot = 16'd1; v_lb = 16'd1;
                    v_fault = 8'($urandom_range(0, 3));
                    v_limit = 8'($urandom_range(0, 3));
                    v_lbb   = 8'($urandom_range(0, 3));
                end
                1:
                begin
                    v_on = 16'hFFFF; v_off = 16'hFFFF; v_hot = 16'hFFFF; v_lb = 16'hFFFF;
                    v_fault = 8'hFF; v_limit = 8'hFF; v_lbb = 8'hFF;
                end
                5:
                begin
                    v_on = RST_BEEP_ON; v_off = RST_BEEP_OFF;
                    v_hot = RST_HOT_PERIOD; v_lb = RST_LOW_BATT_PERIOD;
                    v_fault = RST_FAULT_BEEPS; v_limit = RST_LIMIT_BEEPS;
                    v_lbb = RST_LOW_BATT_BEEPS;
                end
                default:
                begin
                    v_on    = 16'($urandom_range(1, 120));
                    v_off   = 16'($urandom_range(1, 120));
                    v_hot   = 16'($urandom_range(1, 600));
                    v_lb    = 16'($urandom_range(1, 1200));
                    v_fault = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                    v_limit = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                    v_lbb   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                end
            endcase
            write_reg(REG_BEEP_ON, v_on);
            write_reg(REG_BEEP_OFF, v_off);
            write_reg(REG_HOT_PERIOD, v_hot);
            write_reg(REG_LOW_BATT_PERIOD, v_lb);
            write_reg(REG_FAULT_BEEPS, {8'($urandom), v_fault});
            write_reg(REG_LIMIT_BEEPS, {8'($urandom), v_limit});
            write_reg(REG_LOW_BATT_BEEPS, {8'($urandom), v_lbb});
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_UNUSED, 16'($urandom));
            cfg_valid <= 1'b0;
            rx_calm   <= (p == 4);

            // tick steps scaled to the beep timing so bursts actually play out
            scale = (v_on > v_off) ? v_on : v_off;
            scale = scale + scale / 2 + 1;
            if (scale > 65535)
                scale = 65535;
            cur_ts  = therm_t'($urandom_range(0, 3));
            cur_hot = 1'($urandom);
            cur_lb  = 1'($urandom);

            for (i = 0; i < PHASE_BEATS; i++)
            begin
                // sender holds off until all results are back
                if (i == PHASE_BEATS / 2 || $urandom_range(0, 99) == 0)
                    drain_results(DRAIN_LIMIT);

                // alarm inputs persist over many ticks
                if ($urandom_range(0, 9) == 0)
                begin
                    cur_ts  = therm_t'($urandom_range(0, 3));
                    cur_hot = 1'($urandom);
                    cur_lb  = 1'($urandom);
                end

                b.ts    = therm_t'($urandom_range(0, 3));
                b.hot   = 1'($urandom);
                b.lowb  = 1'($urandom);
                b.count = 8'($urandom);
                b.elapsed = 16'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 80)
                begin
                    b.op   = OP_TICK;
                    b.ts   = cur_ts;
                    b.hot  = cur_hot;
                    b.lowb = cur_lb;
                    roll = $urandom_range(0, 9);
                    if (roll == 0)
                        b.elapsed = '0;
                    else if (roll > 1)
                        b.elapsed = 16'($urandom_range(0, scale));
                end
                else if (roll < 88)
                begin
                    b.op = OP_PLAY;
                    if ($urandom_range(0, 3) != 0)
                        b.count = 8'($urandom_range(0, 8));
                end
                else if (roll < 95)
                    b.op = OP_STOP;
                else
                    b.op = OP_IGNORED;

                // sender gaps, none in the calm phases
                gap = 0;
                if (p != 3 && p != 4)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll >= 55 && roll < 85)
                        gap = $urandom_range(1, 3);
                    else if (roll >= 85 && roll < 96)
                        gap = $urandom_range(4, 10);
                    else if (roll >= 96)
                        gap = $urandom_range(15, 50);
                end
                send_beat(b, gap, 1'b0, '0);
            end
        end

        // wait out the last results, then the pipeline latency
        drain_results(DRAIN_LIMIT);
        repeat (8) @(posedge clk);
        if (pending_tones.size() != 0)
        begin
            mismatches += pending_tones.size();
            $display("%0d expected results never arrived", pending_tones.size());
        end

        $display("sent %0d beats (ticks, play, stop, ignored) over %0d register settings",
                 beats_sent, NUM_PHASES + 2);
        $display("compared %0d result beats, %0d mismatches", tones_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: priority_alarm_beep_sequencer_unit.f
design/pabs_pkg.sv
design/priority_alarm_beep_sequencer_unit.sv
test/tb_priority_alarm_beep_sequencer_unit.sv
